/* rtl/bsf_pkg.sv */
// ---------------------------------------------------------------------------
// Bus servo command framer package
// Shared types, codes and the packet byte table for the framer blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package bsf_pkg;

  // Command opcodes as they arrive on the input channel.
  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_SETID = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Fixed packet bytes.
  localparam logic [7:0] HDR_BYTE     = 8'hFF;
  localparam logic [7:0] BCAST_ID     = 8'hFE;
  localparam logic [7:0] LEN_MOVE     = 8'h07;
  localparam logic [7:0] LEN_SHORT    = 8'h04;
  localparam logic [7:0] INS_WRITE    = 8'h03;
  localparam logic [7:0] INS_READ     = 8'h02;
  localparam logic [7:0] ADDR_GOAL    = 8'h2A;
  localparam logic [7:0] ADDR_ID      = 8'h05;
  localparam logic [7:0] ADDR_POS     = 8'h38;
  localparam logic [7:0] READ_CNT     = 8'h02;

  // Validity limits.
  localparam logic [15:0] POS_MIN = 16'd96;
  localparam logic [15:0] POS_MAX = 16'd4000;
  localparam logic [7:0]  ID_MIN  = 8'd1;
  localparam logic [7:0]  ID_MAX  = 8'd250;

  // Byte index within a packet (up to 11 bytes).
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] LAST_MOVE  = 4'd10;
  localparam logic [IDX_W-1:0] LAST_SHORT = 4'd7;
  localparam logic [IDX_W-1:0] SUM_START  = 4'd2;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_MOVE,
    KIND_SETID,
    KIND_READ
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id;
    logic [15:0] pos;
    logic [15:0] tm;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // Index of the checksum byte for a packet kind.
  function automatic logic [IDX_W-1:0] last_idx(kind_t kind);
    last_idx = (kind == KIND_MOVE) ? LAST_MOVE : LAST_SHORT;
  endfunction

  // Packet byte at a given index, checksum position excluded.
  function automatic logic [7:0] pkt_byte(cmd_t cmd, logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = HDR_BYTE;
    case (cmd.kind)
      KIND_MOVE: begin
        case (idx)
          4'd2:    b = cmd.id;
          4'd3:    b = LEN_MOVE;
          4'd4:    b = INS_WRITE;
          4'd5:    b = ADDR_GOAL;
          4'd6:    b = cmd.pos[15:8];
          4'd7:    b = cmd.pos[7:0];
          4'd8:    b = cmd.tm[15:8];
          4'd9:    b = cmd.tm[7:0];
          default: b = HDR_BYTE;
        endcase
      end
      KIND_SETID: begin
        case (idx)
          4'd2:    b = BCAST_ID;
          4'd3:    b = LEN_SHORT;
          4'd4:    b = INS_WRITE;
          4'd5:    b = ADDR_ID;
          4'd6:    b = cmd.id;
          default: b = HDR_BYTE;
        endcase
      end
      KIND_READ: begin
        case (idx)
          4'd2:    b = cmd.id;
          4'd3:    b = LEN_SHORT;
          4'd4:    b = INS_READ;
          4'd5:    b = ADDR_POS;
          4'd6:    b = READ_CNT;
          default: b = HDR_BYTE;
        endcase
      end
      default: b = HDR_BYTE;
    endcase
    pkt_byte = b;
  endfunction

endpackage

`default_nettype wire

/* rtl/bsf_front.sv */
// ---------------------------------------------------------------------------
// Bus servo framer front end
// Accepts commands, checks them and holds one classified command for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module bsf_front
  import bsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_servo_id,
  input  wire logic [15:0] in_position,
  input  wire logic [15:0] in_move_time,
  input  wire logic        q_full,
  output logic             cmd_valid,
  output cmd_t             cmd
);

  logic cmd_valid_r, cmd_valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept, item_ok;
  logic id_ok, pos_ok;

  assign in_full = cmd_valid_r && q_full;
  assign accept  = in_push && !in_full;

  assign id_ok  = (in_servo_id >= ID_MIN) && (in_servo_id <= ID_MAX);
  assign pos_ok = (in_position >= POS_MIN) && (in_position <= POS_MAX);

  always_comb begin
    cmd_nxt.id  = in_servo_id;
    cmd_nxt.pos = in_position;
    cmd_nxt.tm  = in_move_time;
    unique case (in_opcode)
      OP_MOVE: begin
        cmd_nxt.kind = KIND_MOVE;
        item_ok      = pos_ok;
      end
      OP_SETID: begin
        cmd_nxt.kind = KIND_SETID;
        item_ok      = id_ok;
      end
      OP_READ: begin
        cmd_nxt.kind = KIND_READ;
        item_ok      = id_ok;
      end
      default: begin
        cmd_nxt.kind = KIND_MOVE;
        item_ok      = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (accept) begin
      cmd_valid_nxt = item_ok;
    end else if (cmd_valid_r && !q_full) begin
      cmd_valid_nxt = 1'b0;
    end else begin
      cmd_valid_nxt = cmd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

/* rtl/bsf_queue.sv */
// ---------------------------------------------------------------------------
// Bus servo framer command queue
// Short first-in first-out queue of checked commands between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module bsf_queue
  import bsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output q_stat_t   stat
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd = mem[rd_ptr_r];

endmodule

`default_nettype wire

/* rtl/bsf_back.sv */
// ---------------------------------------------------------------------------
// Bus servo framer back end
// Serializes the head command into packet bytes with a running checksum.
// ---------------------------------------------------------------------------
`default_nettype none

module bsf_back
  import bsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        head_cmd,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_tx_byte,
  output logic             out_last_byte
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             load, at_last;
  logic [7:0]       cur_byte;

  assign load    = !q_empty && (!out_valid_r || out_pop);
  assign at_last = (idx_r == last_idx(head_cmd.kind));
  // The checksum is the inverted sum of everything after the two header bytes.
  assign cur_byte = at_last ? ~sum_r : pkt_byte(head_cmd, idx_r);
  assign q_pop    = load && at_last;

  always_comb begin
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (at_last) begin
        idx_nxt = '0;
        sum_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r >= SUM_START) begin
          sum_nxt = sum_r + cur_byte;
        end
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      last_r <= at_last;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_tx_byte   = byte_r;
  assign out_last_byte = last_r;

endmodule

`default_nettype wire

/* rtl/bus_servo_command_framer.sv */
// ---------------------------------------------------------------------------
// Bus servo command framer
// Turns servo commands into serial bus packets, one byte per result.
// ---------------------------------------------------------------------------
// An accepted command moves from the front register into the queue, then the
// output register loads its first packet byte onto the result ports.
// Throughput: one byte per cycle while pop stays high; a move packet is
// 11 bytes and a set-id or read packet 8, set by the byte serializer.
// Reset: synchronous, active low; it empties the queue and the output stage.
`default_nettype none

module bus_servo_command_framer
  import bsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_servo_id,
  input  wire logic [15:0] in_position,
  input  wire logic [15:0] in_move_time,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_tx_byte,
  output logic             out_last_byte
);

  // The front end checks each request and drops the ones that produce no
  // packet, so only real packets ever reach the queue.
  cmd_t    front_cmd;
  logic    front_valid;
  cmd_t    head_cmd;
  q_stat_t q_stat;
  logic    q_pop;

  bsf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_opcode    (in_opcode),
    .in_servo_id  (in_servo_id),
    .in_position  (in_position),
    .in_move_time (in_move_time),
    .q_full       (q_stat.full),
    .cmd_valid    (front_valid),
    .cmd          (front_cmd)
  );

  // The queue lets the front end take new requests while the back end is
  // still shifting out a long packet or is held up by the consumer.
  bsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_valid),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // The back end walks the head command byte by byte, summing the bytes
  // after the header, and retires the command when its checksum goes out.
  bsf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_cmd      (head_cmd),
    .q_empty       (q_stat.empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

  // An accepted unused opcode must never leave a command for the queue.
  a_drop_unused : assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_opcode == OP_NONE) |=> !front_valid)
    else $error("unused opcode reached the command register");

  // The queue occupancy never exceeds its depth.
  a_q_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("command queue over its depth");

  // A command leaves the queue exactly when its checksum byte is loaded.
  a_pop_last : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!out_empty && out_last_byte))
    else $error("command retired without a final byte");

endmodule

`default_nettype wire

/* sim/framer_packet_monitor.sv */
// ---------------------------------------------------------------------------
// Framer packet monitor
// Watches both channels of the servo command framer, builds the packet bytes
// each accepted request should produce and compares every popped byte.
// ---------------------------------------------------------------------------
module framer_packet_monitor
  import bsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_servo_id,
  input  logic [15:0] in_position,
  input  logic [15:0] in_move_time,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_last_byte,
  output int          pending_bytes,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tx_beat_t;

  tx_beat_t packet_bytes_q[$];
  int       errors = 0;

  initial begin
    pending_bytes  = 0;
    mismatch_count = 0;
  end

  // Appends the full packet for one request, or nothing when the request is
  // dropped by the framer.
  task automatic queue_packet(logic [1:0] op, logic [7:0] id, logic [15:0] pos,
                              logic [15:0] tm);
    logic [7:0] body[$];
    logic [7:0] sum;
    body = {};
    sum  = 8'h00;
    case (op)
      OP_MOVE: begin
        if (pos >= POS_MIN && pos <= POS_MAX) begin
          body.push_back(id);
          body.push_back(LEN_MOVE);
          body.push_back(INS_WRITE);
          body.push_back(ADDR_GOAL);
          body.push_back(pos[15:8]);
          body.push_back(pos[7:0]);
          body.push_back(tm[15:8]);
          body.push_back(tm[7:0]);
        end
      end
      OP_SETID: begin
        if (id >= ID_MIN && id <= ID_MAX) begin
          body.push_back(BCAST_ID);
          body.push_back(LEN_SHORT);
          body.push_back(INS_WRITE);
          body.push_back(ADDR_ID);
          body.push_back(id);
        end
      end
      OP_READ: begin
        if (id >= ID_MIN && id <= ID_MAX) begin
          body.push_back(id);
          body.push_back(LEN_SHORT);
          body.push_back(INS_READ);
          body.push_back(ADDR_POS);
          body.push_back(READ_CNT);
        end
      end
      default: begin
      end
    endcase
    if (body.size() != 0) begin
      packet_bytes_q.push_back('{data: HDR_BYTE, last: 1'b0});
      packet_bytes_q.push_back('{data: HDR_BYTE, last: 1'b0});
      foreach (body[i]) begin
        sum = sum + body[i];
        packet_bytes_q.push_back('{data: body[i], last: 1'b0});
      end
      packet_bytes_q.push_back('{data: ~sum, last: 1'b1});
    end
  endtask

  always @(posedge clk) begin
    tx_beat_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (packet_bytes_q.size() == 0) begin
          $error("unexpected packet byte %h (last %b)", out_tx_byte, out_last_byte);
          errors++;
        end else begin
          want = packet_bytes_q.pop_front();
          if (out_tx_byte !== want.data) begin
            $error("tx_byte: expected %h, actual %h", want.data, out_tx_byte);
            errors++;
          end
          if (out_last_byte !== want.last) begin
            $error("last_byte: expected %b, actual %b", want.last, out_last_byte);
            errors++;
          end
        end
      end
      if (in_push && !in_full)
        queue_packet(in_opcode, in_servo_id, in_position, in_move_time);
    end
    pending_bytes  <= packet_bytes_q.size();
    mismatch_count <= errors;
  end

endmodule

/* sim/bus_servo_command_framer_tb.sv */
// ---------------------------------------------------------------------------
// Bus servo command framer testbench
// Drives directed and random servo commands with random gaps on both sides
// and lets the packet monitor check every byte of every emitted packet.
// ---------------------------------------------------------------------------
module bus_servo_command_framer_tb
  import bsf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Random requests after the directed part, ignored opcodes included.
  localparam int RANDOM_REQUESTS = 308;
  // The last requests of the run go out with no idling on either side.
  localparam int CALM_TAIL       = 40;
  // Cycles without any accepted request or byte before the run is abandoned.
  // The slowest correct stretch is a sender gap plus the pipeline latency plus
  // a pop stall, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT  = 2000;
  // Extra cycles after the last expected byte, to catch stray output.
  localparam int SETTLE_CYCLES   = 20;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_push      = 1'b0;
  logic [1:0]  in_opcode    = OP_NONE;
  logic [7:0]  in_servo_id  = 8'h00;
  logic [15:0] in_position  = 16'h0000;
  logic [15:0] in_move_time = 16'h0000;
  logic        out_pop      = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [7:0]  out_tx_byte;
  logic        out_last_byte;

  int pending_bytes;
  int mismatch_count;
  bit calm_phase = 1'b0;

  bus_servo_command_framer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_opcode    (in_opcode),
    .in_servo_id  (in_servo_id),
    .in_position  (in_position),
    .in_move_time (in_move_time),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_tx_byte  (out_tx_byte),
    .out_last_byte(out_last_byte)
  );

  framer_packet_monitor monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_servo_id   (in_servo_id),
    .in_position   (in_position),
    .in_move_time  (in_move_time),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte),
    .pending_bytes (pending_bytes),
    .mismatch_count(mismatch_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Presents one request at a falling edge and holds it until a rising edge
  // accepts it. The push stays high on return, so back-to-back requests
  // simply overwrite the fields at the next falling edge.
  task automatic send_request(logic [1:0] op, logic [7:0] id, logic [15:0] pos,
                              logic [15:0] tm);
    @(negedge clk);
    in_push      <= 1'b1;
    in_opcode    <= op;
    in_servo_id  <= id;
    in_position  <= pos;
    in_move_time <= tm;
    do @(posedge clk); while (in_full);
  endtask

  // Drops the push for a burst of cycles.
  task automatic sender_gap(int cycles);
    @(negedge clk);
    in_push <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Occasionally idles the sender, except during the calm tail of the run.
  task automatic maybe_pause();
    if (!calm_phase && $urandom_range(0, 5) == 0)
      sender_gap($urandom_range(1, 15));
  endtask

  // Holds the sender off until the monitor has seen every expected byte.
  task automatic wait_for_drain();
    @(negedge clk);
    in_push <= 1'b0;
    do @(posedge clk); while (pending_bytes != 0);
  endtask

  // The receiver pops at every falling edge unless it is inside a stall
  // burst. Only one assignment to out_pop happens per falling edge.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("bus_servo_command_framer_tb failed");
    $finish;
  end

  initial begin
    int          sent;
    int          pick;
    logic [1:0]  op;
    logic [7:0]  id;
    logic [15:0] pos;
    logic [15:0] tm;

    sent = 0;
    // Synchronous reset, released at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Moves at both range limits and just outside them, with
    // the id and time fields at their extremes. A move takes any id, even
    // the broadcast id.
    send_request(OP_MOVE, 8'h01, 16'd96, 16'h0000);
    send_request(OP_MOVE, 8'hFF, 16'd4000, 16'hFFFF);
    send_request(OP_MOVE, 8'h00, 16'd95, 16'h1234);
    send_request(OP_MOVE, 8'h05, 16'd4001, 16'h1234);
    send_request(OP_MOVE, 8'h05, 16'h0000, 16'hFFFF);
    send_request(OP_MOVE, 8'h05, 16'hFFFF, 16'h0000);
    send_request(OP_MOVE, BCAST_ID, 16'd2048, 16'h00FF);
    send_request(OP_MOVE, 8'h00, 16'd1000, 16'hFF00);
    maybe_pause();
    // Set-id with the smallest and largest legal id, then rejected ids.
    // Position and time carry junk, which the framer must ignore.
    send_request(OP_SETID, 8'd1, 16'hFFFF, 16'hFFFF);
    send_request(OP_SETID, 8'd250, 16'h0000, 16'h0000);
    send_request(OP_SETID, 8'd0, 16'd500, 16'd10);
    send_request(OP_SETID, 8'd251, 16'd500, 16'd10);
    send_request(OP_SETID, 8'hFF, 16'd500, 16'd10);
    // Read-position requests at the id limits, legal and not.
    send_request(OP_READ, 8'd1, 16'hAAAA, 16'h5555);
    send_request(OP_READ, 8'd250, 16'h5555, 16'hAAAA);
    send_request(OP_READ, 8'd0, 16'd200, 16'd1);
    send_request(OP_READ, 8'd251, 16'd200, 16'd1);
    send_request(OP_READ, BCAST_ID, 16'd200, 16'd1);
    // The unused opcode is dropped whatever the other fields hold.
    send_request(OP_NONE, 8'd10, 16'd1000, 16'd100);
    send_request(OP_NONE, 8'hFF, 16'hFFFF, 16'hFFFF);
    // A legal move right after dropped requests, then a read.
    send_request(OP_MOVE, 8'h7E, 16'd3999, 16'h8001);
    send_request(OP_READ, 8'd128, 16'd0, 16'd0);

    // Let everything drain once before the random part.
    wait_for_drain();

    // Random part. Most requests are legal so that full packets dominate;
    // a share of them carry out-of-range ids or positions.
    while (sent < RANDOM_REQUESTS) begin
      if (sent == RANDOM_REQUESTS / 2)
        wait_for_drain();
      calm_phase = (sent >= RANDOM_REQUESTS - CALM_TAIL);
      pick = $urandom_range(0, 99);
      if (pick < 40)
        op = OP_MOVE;
      else if (pick < 65)
        op = OP_SETID;
      else if (pick < 92)
        op = OP_READ;
      else
        op = OP_NONE;
      tm = 16'($urandom_range(0, 65535));
      if (op == OP_MOVE) begin
        id  = 8'($urandom_range(0, 255));
        pos = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(96, 4000));
      end else begin
        id  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(1, 250));
        pos = 16'($urandom_range(0, 65535));
      end
      sent++;
      send_request(op, id, pos, tm);
      maybe_pause();
    end

    // Wait for the last packet, then run on through the settle time for stray bytes.
    @(negedge clk);
    in_push <= 1'b0;
    do @(posedge clk); while (pending_bytes != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("bus_servo_command_framer_tb passed");
    else
      $display("bus_servo_command_framer_tb failed");
    $finish;
  end

endmodule
